// ----- hdl/ptiu_pkg.sv -----
// shared widths, codes and types of the packed tensor index unit
package ptiu_pkg;

   // default largest spatial dimension
   localparam int unsigned MAX_DIM_DEFAULT = 8;

   // fixed field widths
   localparam int unsigned ACTION_W    = 2;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned DIMENSION_W = 4;
   localparam int unsigned PACKED_W    = 10;

   // dimension register value after reset
   localparam logic [DIMENSION_W-1:0] DIMENSION_RESET = DIMENSION_W'(3);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_SYM   = ACTION_W'(0);
   localparam logic [ACTION_W-1:0] ACT_ANTI  = ACTION_W'(1);
   localparam logic [ACTION_W-1:0] ACT_ELAST = ACTION_W'(2);

   // result error codes
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIM_ZERO = 2'd1,
      ERR_RANGE    = 2'd2,
      ERR_ORDER    = 2'd3
   } err_type;

   // per-item control carried down the pipeline
   typedef struct packed {
      err_type err;
      logic    elast;
   } ctl_type;

endpackage

// ----- hdl/ptiu_req_if.sv -----
// request channel interface: action and four tensor indices
interface ptiu_req_if import ptiu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  first_index;
   logic [INDEX_W-1:0]  second_index;
   logic [INDEX_W-1:0]  third_index;
   logic [INDEX_W-1:0]  fourth_index;

   modport source (
      output valid, action, first_index, second_index, third_index, fourth_index,
      input  ready
   );
   modport sink (
      input  valid, action, first_index, second_index, third_index, fourth_index,
      output ready
   );
endinterface

// ----- hdl/ptiu_rsp_if.sv -----
// response channel interface: packed index and error code
interface ptiu_rsp_if import ptiu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PACKED_W-1:0] packed_index;
   err_type             error_code;

   modport source (
      output valid, packed_index, error_code,
      input  ready
   );
   modport sink (
      input  valid, packed_index, error_code,
      output ready
   );
endinterface

// ----- hdl/ptiu_canon.sv -----
// stage 1: error checks, index canonicalization and component count
module ptiu_canon import ptiu_pkg::*; #(
   parameter  int unsigned MAX_DIM = MAX_DIM_DEFAULT,
   localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1),
   localparam int unsigned NC_W    = $clog2(MAX_DIM * (MAX_DIM + 1) / 2 + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   output logic                   in_rdy,
   input  logic [ACTION_W-1:0]    action,
   input  logic [INDEX_W-1:0]     idx_i,
   input  logic [INDEX_W-1:0]     idx_j,
   input  logic [INDEX_W-1:0]     idx_k,
   input  logic [INDEX_W-1:0]     idx_l,
   input  logic [DIMENSION_W-1:0] dimension,
   output logic                   out_vld,
   input  logic                   out_rdy,
   output ctl_type                out_ctl,
   output logic [DIM_W-1:0]       out_dim,
   output logic [DIM_W-1:0]       out_n_pair,
   output logic [NC_W-1:0]        out_ncomp,
   output logic [INDEX_W-1:0]     out_r0,
   output logic [INDEX_W-1:0]     out_c0,
   output logic [INDEX_W-1:0]     out_r1,
   output logic [INDEX_W-1:0]     out_c1
);

   localparam int unsigned NCF_W = 2 * DIM_W + 1;

   logic                 vld_ff;
   ctl_type              ctl_ff, ctl_in;
   logic [DIM_W-1:0]     dim_ff, dim_in;
   logic [DIM_W-1:0]     n_pair_ff, n_pair_in;
   logic [NC_W-1:0]      ncomp_ff, ncomp_in;
   logic [INDEX_W-1:0]   r0_ff, r0_in, c0_ff, c0_in, r1_ff, r1_in, c1_ff, c1_in;
   logic                 i_oor, j_oor, k_oor, l_oor;
   logic [INDEX_W-1:0]   lo0, hi0, lo1, hi1;
   logic                 swap;
   logic [DIM_W:0]       dim_p1;
   logic [NCF_W-1:0]     ncomp_full;

   // saturate the dimension register to the supported maximum
   assign dim_in = (32'(dimension) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dimension);

   // index range checks
   assign i_oor = 32'(idx_i) >= 32'(dim_in);
   assign j_oor = 32'(idx_j) >= 32'(dim_in);
   assign k_oor = 32'(idx_k) >= 32'(dim_in);
   assign l_oor = 32'(idx_l) >= 32'(dim_in);

   // error priority: bad action, zero dimension, range, order
   always_comb begin
      ctl_in.elast = (action == ACT_ELAST);
      ctl_in.err   = ERR_NONE;
      if (action != ACT_SYM && action != ACT_ANTI && action != ACT_ELAST) begin
         ctl_in.err = ERR_ORDER;
      end else if (dim_in == '0) begin
         ctl_in.err = ERR_DIM_ZERO;
      end else if (i_oor || j_oor || (action == ACT_ELAST && (k_oor || l_oor))) begin
         ctl_in.err = ERR_RANGE;
      end else if (action == ACT_SYM && idx_j < idx_i) begin
         ctl_in.err = ERR_ORDER;
      end else if (action == ACT_ANTI && idx_j <= idx_i) begin
         ctl_in.err = ERR_ORDER;
      end
   end

   // sort each pair, then order the two pairs
   assign lo0  = (idx_j < idx_i) ? idx_j : idx_i;
   assign hi0  = (idx_j < idx_i) ? idx_i : idx_j;
   assign lo1  = (idx_l < idx_k) ? idx_l : idx_k;
   assign hi1  = (idx_l < idx_k) ? idx_k : idx_l;
   assign swap = (lo1 < lo0) || (lo1 == lo0 && hi1 < hi0);

   // row, column and triangle size per mode
   always_comb begin
      r0_in     = idx_i;
      c0_in     = idx_j;
      r1_in     = '0;
      c1_in     = '0;
      n_pair_in = dim_in;
      unique case (action)
         ACT_ELAST: begin
            r0_in = swap ? lo1 : lo0;
            c0_in = swap ? hi1 : hi0;
            r1_in = swap ? lo0 : lo1;
            c1_in = swap ? hi0 : hi1;
         end
         ACT_ANTI: begin
            c0_in     = idx_j - INDEX_W'(1);
            n_pair_in = dim_in - DIM_W'(1);
         end
         default: begin
            r0_in = idx_i;
         end
      endcase
   end

   // components of a symmetric rank-2 tensor: dim*(dim+1)/2
   assign dim_p1     = {1'b0, dim_in} + (DIM_W + 1)'(1);
   assign ncomp_full = NCF_W'(dim_in) * NCF_W'(dim_p1);
   assign ncomp_in   = NC_W'(ncomp_full >> 1);

   // stage handshake
   assign in_rdy = !vld_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_vld && in_rdy) begin
         ctl_ff    <= ctl_in;
         dim_ff    <= dim_in;
         n_pair_ff <= n_pair_in;
         ncomp_ff  <= ncomp_in;
         r0_ff     <= r0_in;
         c0_ff     <= c0_in;
         r1_ff     <= r1_in;
         c1_ff     <= c1_in;
      end
   end

   assign out_vld    = vld_ff;
   assign out_ctl    = ctl_ff;
   assign out_dim    = dim_ff;
   assign out_n_pair = n_pair_ff;
   assign out_ncomp  = ncomp_ff;
   assign out_r0     = r0_ff;
   assign out_c0     = c0_ff;
   assign out_r1     = r1_ff;
   assign out_c1     = c1_ff;

endmodule

// ----- hdl/ptiu_pair.sv -----
// stage 2: symmetric packing of each index pair
module ptiu_pair import ptiu_pkg::*; #(
   parameter  int unsigned MAX_DIM = MAX_DIM_DEFAULT,
   localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1),
   localparam int unsigned NC_W    = $clog2(MAX_DIM * (MAX_DIM + 1) / 2 + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   output logic               in_rdy,
   input  ctl_type            in_ctl,
   input  logic [DIM_W-1:0]   in_dim,
   input  logic [DIM_W-1:0]   in_n_pair,
   input  logic [NC_W-1:0]    in_ncomp,
   input  logic [INDEX_W-1:0] in_r0,
   input  logic [INDEX_W-1:0] in_c0,
   input  logic [INDEX_W-1:0] in_r1,
   input  logic [INDEX_W-1:0] in_c1,
   output logic               out_vld,
   input  logic               out_rdy,
   output ctl_type            out_ctl,
   output logic [NC_W-1:0]    out_ncomp,
   output logic [NC_W-1:0]    out_pi,
   output logic [NC_W-1:0]    out_pj
);

   localparam int unsigned TW = INDEX_W + DIM_W + 1;
   localparam int unsigned HW = 2 * INDEX_W;

   logic            vld_ff;
   ctl_type         ctl_ff;
   logic [NC_W-1:0] ncomp_ff;
   logic [NC_W-1:0] pi_ff, pi_in, pj_ff, pj_in;

   // upper-triangle position of (r, c), r <= c, in an n x n matrix
   function automatic logic [NC_W-1:0] tri_pos(input logic [INDEX_W-1:0] r,
                                               input logic [INDEX_W-1:0] c,
                                               input logic [DIM_W-1:0]   n);
      logic [INDEX_W-1:0] rm1;
      logic [HW-1:0]      half;
      logic [TW-1:0]      pos;
      rm1  = (r == '0) ? '0 : r - INDEX_W'(1);
      half = (HW'(r) * HW'(rm1)) >> 1;
      pos  = TW'(r) * TW'(n) - TW'(half) + (TW'(c) - TW'(r));
      return NC_W'(pos);
   endfunction

   assign pi_in = tri_pos(in_r0, in_c0, in_n_pair);
   assign pj_in = tri_pos(in_r1, in_c1, in_dim);

   // stage handshake
   assign in_rdy = !vld_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_vld && in_rdy) begin
         ctl_ff   <= in_ctl;
         ncomp_ff <= in_ncomp;
         pi_ff    <= pi_in;
         pj_ff    <= pj_in;
      end
   end

   assign out_vld   = vld_ff;
   assign out_ctl   = ctl_ff;
   assign out_ncomp = ncomp_ff;
   assign out_pi    = pi_ff;
   assign out_pj    = pj_ff;

endmodule

// ----- hdl/ptiu_tri.sv -----
// stage 3: products of the outer triangle packing
module ptiu_tri import ptiu_pkg::*; #(
   parameter  int unsigned MAX_DIM = MAX_DIM_DEFAULT,
   localparam int unsigned NC_W    = $clog2(MAX_DIM * (MAX_DIM + 1) / 2 + 1),
   localparam int unsigned SUM_W   = 2 * NC_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   output logic             in_rdy,
   input  ctl_type          in_ctl,
   input  logic [NC_W-1:0]  in_ncomp,
   input  logic [NC_W-1:0]  in_pi,
   input  logic [NC_W-1:0]  in_pj,
   output logic             out_vld,
   input  logic             out_rdy,
   output ctl_type          out_ctl,
   output logic [SUM_W-1:0] out_prod,
   output logic [SUM_W-1:0] out_half,
   output logic [NC_W-1:0]  out_diff
);

   logic             vld_ff;
   ctl_type          ctl_ff;
   logic [SUM_W-1:0] prod_ff, prod_in, half_ff, half_in;
   logic [NC_W-1:0]  diff_ff, diff_in;
   logic [NC_W-1:0]  row, col, row_m1;

   // pair modes pass pi through as row 0; elasticity packs (min, max)
   always_comb begin
      row = '0;
      col = in_pi;
      if (in_ctl.elast) begin
         row = (in_pi < in_pj) ? in_pi : in_pj;
         col = (in_pi < in_pj) ? in_pj : in_pi;
      end
   end

   // row*ncomp, row*(row-1)/2 and column offset
   assign row_m1  = (row == '0) ? '0 : row - NC_W'(1);
   assign prod_in = SUM_W'(row) * SUM_W'(in_ncomp);
   assign half_in = (SUM_W'(row) * SUM_W'(row_m1)) >> 1;
   assign diff_in = col - row;

   // stage handshake
   assign in_rdy = !vld_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_vld && in_rdy) begin
         ctl_ff  <= in_ctl;
         prod_ff <= prod_in;
         half_ff <= half_in;
         diff_ff <= diff_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_ctl  = ctl_ff;
   assign out_prod = prod_ff;
   assign out_half = half_ff;
   assign out_diff = diff_ff;

endmodule

// ----- hdl/ptiu_sum.sv -----
// stage 4: final sum, error masking and output register
module ptiu_sum import ptiu_pkg::*; #(
   parameter  int unsigned MAX_DIM = MAX_DIM_DEFAULT,
   localparam int unsigned NC_W    = $clog2(MAX_DIM * (MAX_DIM + 1) / 2 + 1),
   localparam int unsigned SUM_W   = 2 * NC_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   output logic                in_rdy,
   input  ctl_type             in_ctl,
   input  logic [SUM_W-1:0]    in_prod,
   input  logic [SUM_W-1:0]    in_half,
   input  logic [NC_W-1:0]     in_diff,
   output logic                out_vld,
   input  logic                out_rdy,
   output logic [PACKED_W-1:0] packed_index,
   output err_type             error_code
);

   logic                      vld_ff;
   logic [PACKED_W-1:0]       packed_ff, packed_in;
   err_type                   err_ff;
   logic [SUM_W-1:0]          sum;
   logic [SUM_W+PACKED_W-1:0] sum_ext;

   // packed position, forced to zero on any error
   assign sum       = in_prod - in_half + SUM_W'(in_diff);
   assign sum_ext   = (in_ctl.err == ERR_NONE) ? {{PACKED_W{1'b0}}, sum} : '0;
   assign packed_in = sum_ext[PACKED_W-1:0];

   // output register handshake
   assign in_rdy = !vld_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_vld && in_rdy) begin
         packed_ff <= packed_in;
         err_ff    <= in_ctl.err;
      end
   end

   assign out_vld      = vld_ff;
   assign packed_index = packed_ff;
   assign error_code   = err_ff;

endmodule

// ----- hdl/packed_tensor_index_unit.sv -----
// top level of the packed tensor index unit
// Maps a tensor component to its position in packed storage: a symmetric pair to the
// upper triangle with diagonal, an antisymmetric pair to the strict upper triangle, or a
// rank-4 elasticity component (made canonical first) to the upper triangle of the
// pair-index matrix. The dimension register (csr_wr_data, reset value 3, saturated to
// MAX_DIM) is written whenever csr_wr_en is high and should change only while no item is
// in flight. The block takes one request per cycle unless the pipeline is stalled, and
// returns its response through four register stages: canonicalization, pair packing,
// outer products and the final sum; each stage holds its item while the next is stalled,
// so a waiting response does not stop new requests from entering the empty stages.
module packed_tensor_index_unit import ptiu_pkg::*; #(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   ptiu_req_if.sink               req_ch,
   ptiu_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [DIMENSION_W-1:0] csr_wr_data
);

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam int unsigned NC_W  = $clog2(MAX_DIM * (MAX_DIM + 1) / 2 + 1);
   localparam int unsigned SUM_W = 2 * NC_W;

   logic [DIMENSION_W-1:0] dimension_ff;

   logic                   s1_vld, s1_rdy;
   ctl_type                s1_ctl;
   logic [DIM_W-1:0]       s1_dim, s1_n_pair;
   logic [NC_W-1:0]        s1_ncomp;
   logic [INDEX_W-1:0]     s1_r0, s1_c0, s1_r1, s1_c1;

   logic                   s2_vld, s2_rdy;
   ctl_type                s2_ctl;
   logic [NC_W-1:0]        s2_ncomp, s2_pi, s2_pj;

   logic                   s3_vld, s3_rdy;
   ctl_type                s3_ctl;
   logic [SUM_W-1:0]       s3_prod, s3_half;
   logic [NC_W-1:0]        s3_diff;

   logic                   s4_rdy;

   // dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIMENSION_RESET;
      end else if (csr_wr_en) begin
         dimension_ff <= csr_wr_data;
      end
   end

   // stage 1: checks and canonical order
   ptiu_canon #(.MAX_DIM(MAX_DIM)) u_canon (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (req_ch.valid),
      .in_rdy     (req_ch.ready),
      .action     (req_ch.action),
      .idx_i      (req_ch.first_index),
      .idx_j      (req_ch.second_index),
      .idx_k      (req_ch.third_index),
      .idx_l      (req_ch.fourth_index),
      .dimension  (dimension_ff),
      .out_vld    (s1_vld),
      .out_rdy    (s1_rdy),
      .out_ctl    (s1_ctl),
      .out_dim    (s1_dim),
      .out_n_pair (s1_n_pair),
      .out_ncomp  (s1_ncomp),
      .out_r0     (s1_r0),
      .out_c0     (s1_c0),
      .out_r1     (s1_r1),
      .out_c1     (s1_c1)
   );

   // stage 2: pair packing
   ptiu_pair #(.MAX_DIM(MAX_DIM)) u_pair (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (s1_vld),
      .in_rdy    (s1_rdy),
      .in_ctl    (s1_ctl),
      .in_dim    (s1_dim),
      .in_n_pair (s1_n_pair),
      .in_ncomp  (s1_ncomp),
      .in_r0     (s1_r0),
      .in_c0     (s1_c0),
      .in_r1     (s1_r1),
      .in_c1     (s1_c1),
      .out_vld   (s2_vld),
      .out_rdy   (s2_rdy),
      .out_ctl   (s2_ctl),
      .out_ncomp (s2_ncomp),
      .out_pi    (s2_pi),
      .out_pj    (s2_pj)
   );

   // stage 3: outer triangle products
   ptiu_tri #(.MAX_DIM(MAX_DIM)) u_tri (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s2_vld),
      .in_rdy   (s2_rdy),
      .in_ctl   (s2_ctl),
      .in_ncomp (s2_ncomp),
      .in_pi    (s2_pi),
      .in_pj    (s2_pj),
      .out_vld  (s3_vld),
      .out_rdy  (s3_rdy),
      .out_ctl  (s3_ctl),
      .out_prod (s3_prod),
      .out_half (s3_half),
      .out_diff (s3_diff)
   );

   // stage 4: sum and response register
   ptiu_sum #(.MAX_DIM(MAX_DIM)) u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (s3_vld),
      .in_rdy       (s3_rdy),
      .in_ctl       (s3_ctl),
      .in_prod      (s3_prod),
      .in_half      (s3_half),
      .in_diff      (s3_diff),
      .out_vld      (rsp_ch.valid),
      .out_rdy      (s4_rdy),
      .packed_index (rsp_ch.packed_index),
      .error_code   (rsp_ch.error_code)
   );

   assign s4_rdy = rsp_ch.ready;

endmodule
